/* rtl/core/fpq_pkg.sv */
// ----------------------------------------------------------------------------
// fpq_pkg
// Shared types and constants for the framed command parser queue.
// ----------------------------------------------------------------------------
package fpq_pkg;

   localparam logic [1:0] OP_FEED  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   localparam logic [7:0] HDR0       = 8'h6B;
   localparam logic [7:0] HDR1       = 8'h79;
   localparam logic [7:0] HDR2       = 8'h00;
   localparam logic [7:0] HDR3       = 8'h81;
   localparam logic [7:0] TAIL       = 8'hFB;
   localparam logic [7:0] CHECK_BIAS = 8'h65;

   localparam int LINK_DEPTH   = 2;
   localparam int RESULT_DEPTH = 4;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR1,
      PH_HDR2,
      PH_HDR3,
      PH_CMD,
      PH_PAD,
      PH_CHECK,
      PH_TAIL
   } phase_type;

   typedef enum logic [1:0] {
      ACT_FEED,
      ACT_POP,
      ACT_FLUSH,
      ACT_NONE
   } act_kind_type;

   typedef struct packed {
      act_kind_type kind;
      logic         push;
      logic [7:0]   cmd;
   } action_type;

   typedef struct packed {
      logic        cmd_valid;
      logic [7:0]  cmd_value;
      logic        frame_done;
      logic [2:0]  pending_count;
      logic [31:0] frames_accepted;
      logic [7:0]  latest_cmd;
      logic [31:0] bytes_seen;
   } result_type;

endpackage

/* rtl/core/framed_command_parser_queue.sv */
// ----------------------------------------------------------------------------
// framed_command_parser_queue
// Parses 6B 79 00 81 CMD PAD CHECK FB frames and queues valid commands.
// ----------------------------------------------------------------------------
// One transfer per cycle sustained on both sides: each feed, pop, flush or
// unused operation yields one result on the result ports (parser into a
// two-entry action FIFO, queue engine with a registered command memory
// read, then a four-entry result FIFO). The input stalls only when the
// result FIFO backs up. The command memory of QUEUE_DEPTH entries holds
// at most QUEUE_DEPTH-1 commands and drops the oldest when a new frame
// arrives on a full queue.
// Flush clears parser and queue; counters and latest_cmd are kept.
module framed_command_parser_queue #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_cmd_valid,
   output logic [7:0]  rsp_cmd_value,
   output logic        rsp_frame_done,
   output logic [2:0]  rsp_pending_count,
   output logic [31:0] rsp_frames_accepted,
   output logic [7:0]  rsp_latest_cmd,
   output logic [31:0] rsp_bytes_seen
);

   import fpq_pkg::*;

   localparam int AW  = $bits(action_type);
   localparam int RW  = $bits(result_type);
   localparam int LCW = $clog2(LINK_DEPTH + 1);
   localparam int RCW = $clog2(RESULT_DEPTH + 1);

   logic             accept;
   action_type       front_action, back_action;
   logic [AW-1:0]    link_rd;
   logic             link_full, link_empty, link_pop;
   logic [LCW-1:0]   link_count;
   logic             res_push, res_full;
   result_type       back_result, out_result;
   logic [RW-1:0]    res_rd;
   logic [RCW-1:0]   res_count;

   assign accept   = req_push && !link_full;
   assign req_full = link_full;

   fpq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .rx_byte   (req_rx_byte),
      .action    (front_action)
   );

   fpq_fifo #(
      .WIDTH (AW),
      .DEPTH (LINK_DEPTH)
   ) u_link (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_data (front_action),
      .pop     (link_pop),
      .rd_data (link_rd),
      .full    (link_full),
      .empty   (link_empty),
      .count   (link_count)
   );

   assign back_action = action_type'(link_rd);

   fpq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .link_valid (!link_empty && (link_count != '0)),
      .action     (back_action),
      .link_pop   (link_pop),
      .res_count  (res_count),
      .res_push   (res_push),
      .result     (back_result)
   );

   fpq_fifo #(
      .WIDTH (RW),
      .DEPTH (RESULT_DEPTH)
   ) u_result (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (back_result),
      .pop     (rsp_pop),
      .rd_data (res_rd),
      .full    (res_full),
      .empty   (rsp_empty),
      .count   (res_count)
   );

   assign out_result          = result_type'(res_rd);
   assign rsp_cmd_valid       = out_result.cmd_valid && !res_full | out_result.cmd_valid;
   assign rsp_cmd_value       = out_result.cmd_value;
   assign rsp_frame_done      = out_result.frame_done;
   assign rsp_pending_count   = out_result.pending_count;
   assign rsp_frames_accepted = out_result.frames_accepted;
   assign rsp_latest_cmd      = out_result.latest_cmd;
   assign rsp_bytes_seen      = out_result.bytes_seen;

endmodule

/* rtl/core/fpq_fifo.sv */
// ----------------------------------------------------------------------------
// fpq_fifo
// Small register FIFO used between the parser and the queue engine and on the
// result side.
// ----------------------------------------------------------------------------
module fpq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = data_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/core/fpq_front.sv */
// ----------------------------------------------------------------------------
// fpq_front
// Frame parser: tracks the header/command/check/tail phase and turns each
// accepted transfer into an action for the queue engine.
// ----------------------------------------------------------------------------
module fpq_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [1:0]         operation,
   input  logic [7:0]         rx_byte,
   output fpq_pkg::action_type action
);

   import fpq_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;

   function automatic phase_type header_miss(input logic [7:0] b);
      header_miss = (b == HDR0) ? PH_HDR1 : PH_IDLE;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      if (accept) begin
         case (operation)
            OP_FEED: begin
               case (phase_ff)
                  PH_IDLE:  phase_in = (rx_byte == HDR0) ? PH_HDR1 : PH_IDLE;
                  PH_HDR1:  phase_in = (rx_byte == HDR1) ? PH_HDR2 : header_miss(rx_byte);
                  PH_HDR2:  phase_in = (rx_byte == HDR2) ? PH_HDR3 : header_miss(rx_byte);
                  PH_HDR3:  phase_in = (rx_byte == HDR3) ? PH_CMD : header_miss(rx_byte);
                  PH_CMD: begin
                     held_in  = rx_byte;
                     phase_in = PH_PAD;
                  end
                  PH_PAD:   phase_in = PH_CHECK;
                  PH_CHECK: phase_in = (rx_byte == held_ff + CHECK_BIAS) ? PH_TAIL : PH_IDLE;
                  PH_TAIL:  phase_in = PH_IDLE;
                  default:  phase_in = PH_IDLE;
               endcase
            end
            OP_FLUSH: begin
               phase_in = PH_IDLE;
               held_in  = '0;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (operation)
         OP_FEED:  action.kind = ACT_FEED;
         OP_POP:   action.kind = ACT_POP;
         OP_FLUSH: action.kind = ACT_FLUSH;
         default:  action.kind = ACT_NONE;
      endcase
      action.push = (operation == OP_FEED) && (phase_ff == PH_TAIL) && (rx_byte == TAIL);
      action.cmd  = held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

/* rtl/core/fpq_back.sv */
// ----------------------------------------------------------------------------
// fpq_back
// Queue engine: ring queue of commands, frame and byte counters, and a
// two-stage path that builds one result per action.
// ----------------------------------------------------------------------------
module fpq_back #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         link_valid,
   input  fpq_pkg::action_type                          action,
   output logic                                         link_pop,
   input  logic [$clog2(fpq_pkg::RESULT_DEPTH+1)-1:0]   res_count,
   output logic                                         res_push,
   output fpq_pkg::result_type                          result
);

   import fpq_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int PW    = (PTR_W + 1 > 3) ? PTR_W + 1 : 3;
   localparam int RCW   = $clog2(RESULT_DEPTH + 1);

   logic [7:0]       mem [QUEUE_DEPTH];
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] rp_ff, rp_in, wp_ff, wp_in, wp_next;
   logic [31:0]      frames_ff, frames_in, bytes_ff, bytes_in;
   logic [7:0]       latest_ff, latest_in;
   logic             issue, mem_we, pop_hit;
   logic [PW-1:0]    pend_wide;

   logic             s2_valid_ff;
   logic             s2_hit_ff;
   logic             s2_done_ff;
   logic [2:0]       s2_pend_ff;
   logic [31:0]      s2_frames_ff, s2_bytes_ff;
   logic [7:0]       s2_latest_ff;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign issue    = link_valid &&
                     ((RCW + 1)'(res_count) + (RCW + 1)'(s2_valid_ff) <
                      (RCW + 1)'(RESULT_DEPTH));
   assign link_pop = issue;
   assign wp_next  = ring_next(wp_ff);

   always_comb begin
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      frames_in = frames_ff;
      bytes_in  = bytes_ff;
      latest_in = latest_ff;
      mem_we    = 1'b0;
      pop_hit   = 1'b0;
      if (issue) begin
         case (action.kind)
            ACT_FEED: begin
               bytes_in = bytes_ff + 32'd1;
               if (action.push) begin
                  mem_we    = 1'b1;
                  wp_in     = wp_next;
                  rp_in     = (wp_next == rp_ff) ? ring_next(rp_ff) : rp_ff;
                  frames_in = frames_ff + 32'd1;
                  latest_in = action.cmd;
               end
            end
            ACT_POP: begin
               if (rp_ff != wp_ff) begin
                  pop_hit = 1'b1;
                  rp_in   = ring_next(rp_ff);
               end
            end
            ACT_FLUSH: begin
               rp_in = '0;
               wp_in = '0;
            end
            default: begin
               rp_in = rp_ff;
            end
         endcase
      end
      pend_wide = PW'(wp_in) + ((wp_in < rp_in) ? PW'(QUEUE_DEPTH) : PW'(0)) - PW'(rp_in);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= action.cmd;
      end
      rd_data_ff <= mem[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff       <= '0;
         wp_ff       <= '0;
         frames_ff   <= '0;
         bytes_ff    <= '0;
         latest_ff   <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         frames_ff   <= frames_in;
         bytes_ff    <= bytes_in;
         latest_ff   <= latest_in;
         s2_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s2_hit_ff    <= pop_hit;
         s2_done_ff   <= (action.kind == ACT_FEED) && action.push;
         s2_pend_ff   <= pend_wide[2:0];
         s2_frames_ff <= frames_in;
         s2_bytes_ff  <= bytes_in;
         s2_latest_ff <= latest_in;
      end
   end

   assign res_push               = s2_valid_ff;
   assign result.cmd_valid       = s2_hit_ff;
   assign result.cmd_value       = s2_hit_ff ? rd_data_ff : 8'd0;
   assign result.frame_done      = s2_done_ff;
   assign result.pending_count   = s2_pend_ff;
   assign result.frames_accepted = s2_frames_ff;
   assign result.latest_cmd      = s2_latest_ff;
   assign result.bytes_seen      = s2_bytes_ff;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for framed_command_parser_queue. A scoreboard class predicts the
// status result of every feed, pop, flush and unused operation and checks each
// response transfer in order. Stimulus is a short directed set followed by
// random frames (good and damaged), noise bytes, pops and flushes, with random
// idle bursts on both sides, a long response hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
   import fpq_pkg::*;

   localparam int QDEPTH = 8;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LONG_HOLD = 120;
   localparam int RANDOM_ITEMS = 1000;
   localparam int CALM_ITEMS = 150;

   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_HDR,
      FRAME_STRAY_HDR,
      FRAME_BAD_CHECK,
      FRAME_BAD_TAIL
   } frame_flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_operation = OP_FEED;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_cmd_valid;
   logic [7:0]  rsp_cmd_value;
   logic        rsp_frame_done;
   logic [2:0]  rsp_pending_count;
   logic [31:0] rsp_frames_accepted;
   logic [7:0]  rsp_latest_cmd;
   logic [31:0] rsp_bytes_seen;

   bit tx_gaps_on = 1'b1;
   bit rx_gaps_on = 1'b1;
   bit hold_request = 1'b0;

   always #1 clock = ~clock;

   framed_command_parser_queue #(.QUEUE_DEPTH(QDEPTH)) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_operation       (req_operation),
      .req_rx_byte         (req_rx_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_cmd_valid       (rsp_cmd_valid),
      .rsp_cmd_value       (rsp_cmd_value),
      .rsp_frame_done      (rsp_frame_done),
      .rsp_pending_count   (rsp_pending_count),
      .rsp_frames_accepted (rsp_frames_accepted),
      .rsp_latest_cmd      (rsp_latest_cmd),
      .rsp_bytes_seen      (rsp_bytes_seen)
   );

   class parser_queue_scoreboard;
      phase_type   phase = PH_IDLE;
      logic [7:0]  held_cmd = 8'h00;
      logic [7:0]  cmd_ring [QDEPTH];
      int          rd_ptr = 0;
      int          wr_ptr = 0;
      logic [31:0] frame_cnt = '0;
      logic [31:0] byte_cnt = '0;
      logic [7:0]  last_cmd = 8'h00;
      result_type  awaited_status [$];
      int          errors = 0;
      int          items = 0;
      int          popped = 0;
      int          flushes = 0;
      int          drops = 0;
      int          empty_pops = 0;

      function int ring_next(int p);
         return (p + 1) % QDEPTH;
      endfunction

      function void queue_cmd(logic [7:0] cmd);
         int nxt;
         nxt = ring_next(wr_ptr);
         if (nxt == rd_ptr) begin
            rd_ptr = ring_next(rd_ptr);
            drops++;
         end
         cmd_ring[wr_ptr] = cmd;
         wr_ptr = nxt;
      endfunction

      function logic parse_byte(logic [7:0] b);
         logic done;
         done = 1'b0;
         case (phase)
            PH_IDLE: if (b == HDR0) phase = PH_HDR1;
            PH_HDR1: phase = (b == HDR1) ? PH_HDR2 : ((b == HDR0) ? PH_HDR1 : PH_IDLE);
            PH_HDR2: phase = (b == HDR2) ? PH_HDR3 : ((b == HDR0) ? PH_HDR1 : PH_IDLE);
            PH_HDR3: phase = (b == HDR3) ? PH_CMD : ((b == HDR0) ? PH_HDR1 : PH_IDLE);
            PH_CMD: begin
               held_cmd = b;
               phase = PH_PAD;
            end
            PH_PAD: phase = PH_CHECK;
            PH_CHECK: phase = (b == 8'(held_cmd + CHECK_BIAS)) ? PH_TAIL : PH_IDLE;
            PH_TAIL: begin
               if (b == TAIL) begin
                  queue_cmd(held_cmd);
                  frame_cnt++;
                  last_cmd = held_cmd;
                  done = 1'b1;
               end
               phase = PH_IDLE;
            end
            default: phase = PH_IDLE;
         endcase
         return done;
      endfunction

      function void take_request(logic [1:0] op, logic [7:0] b);
         result_type r;
         r = '0;
         items++;
         case (op)
            OP_FEED: begin
               byte_cnt++;
               r.frame_done = parse_byte(b);
            end
            OP_POP: begin
               if (rd_ptr != wr_ptr) begin
                  r.cmd_valid = 1'b1;
                  r.cmd_value = cmd_ring[rd_ptr];
                  rd_ptr = ring_next(rd_ptr);
                  popped++;
               end else begin
                  empty_pops++;
               end
            end
            OP_FLUSH: begin
               phase = PH_IDLE;
               held_cmd = 8'h00;
               rd_ptr = 0;
               wr_ptr = 0;
               flushes++;
            end
            default: ;
         endcase
         r.pending_count = 3'((wr_ptr + QDEPTH - rd_ptr) % QDEPTH);
         r.frames_accepted = frame_cnt;
         r.latest_cmd = last_cmd;
         r.bytes_seen = byte_cnt;
         awaited_status.push_back(r);
      endfunction

      function void check_response(result_type got);
         result_type exp;
         if (awaited_status.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: response transfer with nothing expected", $realtime);
            return;
         end
         exp = awaited_status.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: mismatch", $realtime);
               $display("  exp valid=%b value=%h done=%b pend=%0d frames=%0d latest=%h bytes=%0d",
                  exp.cmd_valid, exp.cmd_value, exp.frame_done, exp.pending_count,
                  exp.frames_accepted, exp.latest_cmd, exp.bytes_seen);
               $display("  got valid=%b value=%h done=%b pend=%0d frames=%0d latest=%h bytes=%0d",
                  got.cmd_valid, got.cmd_value, got.frame_done, got.pending_count,
                  got.frames_accepted, got.latest_cmd, got.bytes_seen);
            end
         end
      endfunction

      function int outstanding();
         return awaited_status.size();
      endfunction
   endclass

   parser_queue_scoreboard sb = new;

   // Called at a rising edge; returns at the edge of the transfer.
   task automatic send_item(input logic [1:0] op, input logic [7:0] b);
      if (tx_gaps_on && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_operation <= op;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.take_request(op, b);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(OP_FEED, b);
   endtask

   task automatic send_frame(input logic [7:0] cmd, input frame_flaw_type flaw);
      logic [7:0] hdr [4];
      logic [7:0] bad;
      int pos;
      hdr[0] = HDR0;
      hdr[1] = HDR1;
      hdr[2] = HDR2;
      hdr[3] = HDR3;
      pos = $urandom_range(1, 3);
      if (flaw == FRAME_STRAY_HDR)
         for (int i = 0; i < pos; i++) send_byte(hdr[i]);
      for (int i = 0; i < 4; i++) begin
         if (flaw == FRAME_BAD_HDR && i == pos) begin
            do bad = 8'($urandom_range(0, 255)); while (bad == hdr[i] || bad == HDR0);
            send_byte(bad);
            return;
         end
         send_byte(hdr[i]);
      end
      send_byte(cmd);
      send_byte(8'($urandom_range(0, 255)));
      if (flaw == FRAME_BAD_CHECK)
         send_byte(8'(cmd + CHECK_BIAS + 8'($urandom_range(1, 255))));
      else
         send_byte(8'(cmd + CHECK_BIAS));
      if (flaw == FRAME_BAD_TAIL) begin
         do bad = 8'($urandom_range(0, 255)); while (bad == TAIL);
         send_byte(bad);
      end else begin
         send_byte(TAIL);
      end
   endtask

   task automatic drain_all();
      req_push <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic random_step();
      int pick;
      int flaw_pick;
      frame_flaw_type flaw;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         flaw_pick = $urandom_range(0, 99);
         if (flaw_pick < 80) flaw = FRAME_GOOD;
         else if (flaw_pick < 85) flaw = FRAME_BAD_HDR;
         else if (flaw_pick < 90) flaw = FRAME_STRAY_HDR;
         else if (flaw_pick < 95) flaw = FRAME_BAD_CHECK;
         else flaw = FRAME_BAD_TAIL;
         send_frame(8'($urandom_range(0, 255)), flaw);
      end else if (pick < 85) begin
         send_item(OP_POP, 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 98) begin
         send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
      end else begin
         send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : response_side
      int burst_left;
      int hold_left;
      result_type got;
      burst_left = 0;
      hold_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            got.cmd_valid = rsp_cmd_valid;
            got.cmd_value = rsp_cmd_value;
            got.frame_done = rsp_frame_done;
            got.pending_count = rsp_pending_count;
            got.frames_accepted = rsp_frames_accepted;
            got.latest_cmd = rsp_latest_cmd;
            got.bytes_seen = rsp_bytes_seen;
            sb.check_response(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_pop <= 1'b0;
         end else if (rx_gaps_on && $urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(1, 14) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin : run_limit
      #1000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : request_side
      int guard;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pop, unused op, stray header restart with cmd FF
      send_item(OP_POP, 8'hFF);
      send_item(OP_UNUSED, 8'h00);
      send_byte(HDR0);
      send_byte(HDR1);
      send_byte(HDR0);
      send_byte(HDR1);
      send_byte(HDR2);
      send_byte(HDR3);
      send_byte(8'hFF);
      send_byte(8'h5A);
      send_byte(8'(8'hFF + CHECK_BIAS));
      send_byte(TAIL);
      send_item(OP_POP, 8'h00);
      // bad tail on cmd 00, then flush while a pending frame is half parsed
      send_frame(8'h00, FRAME_BAD_TAIL);
      send_byte(HDR0);
      send_item(OP_FLUSH, 8'hA5);
      send_item(OP_POP, 8'h00);

      // long response hold-off with back-to-back frames: fills and overflows
      drain_all();
      tx_gaps_on = 1'b0;
      hold_request = 1'b1;
      repeat (QDEPTH + 1) send_frame(8'($urandom_range(0, 255)), FRAME_GOOD);
      tx_gaps_on = 1'b1;
      drain_all();

      while (sb.items < RANDOM_ITEMS) random_step();
      drain_all();
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      while (sb.items < RANDOM_ITEMS + CALM_ITEMS) random_step();

      req_push <= 1'b0;
      guard = 0;
      while (sb.outstanding() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (sb.outstanding() != 0) begin
         sb.errors++;
         $display("%0d expected responses never arrived", sb.outstanding());
      end

      $display("Covered %0d transfers: %0d frames queued, %0d overflow drops, %0d flushes",
         sb.items, sb.frame_cnt, sb.drops, sb.flushes);
      $display("Pops returned %0d commands and %0d empty results; %0d errors",
         sb.popped, sb.empty_pops, sb.errors);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
